FILE: design/sile_pkg.sv
// ----------------------------------------------------------------------------
// sile_pkg
// Shared codes and the command struct of the sorted insert list engine.
// ----------------------------------------------------------------------------
package sile_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 5;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_SORTED_INS = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                     en;
    logic [1:0]               op;
    logic signed [ValueW-1:0] value;
  } sile_cmd_t;

endpackage

FILE: design/sile_cell.sv
// ----------------------------------------------------------------------------
// sile_cell
// One list slot: compares against the incoming value, passes the insert
// search flag on to the next slot and shifts toward head or tail.
// ----------------------------------------------------------------------------
module sile_cell
  import sile_pkg::*;
(
  input  logic                     clk,
  input  sile_cmd_t                cmd,
  input  logic                     occ,
  input  logic signed [ValueW-1:0] left_val,
  input  logic signed [ValueW-1:0] right_val,
  input  logic                     pass_in,
  output logic                     pass_out,
  output logic signed [ValueW-1:0] val
);

  logic signed [ValueW-1:0] val_r;
  logic signed [ValueW-1:0] val_nxt;

  assign pass_out = pass_in && occ && (val_r < cmd.value);

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      OP_PUSH_FRONT: val_nxt = left_val;
      OP_SORTED_INS: begin
        if (pass_out) begin
          val_nxt = val_r;
        end else if (pass_in) begin
          val_nxt = cmd.value;
        end else begin
          val_nxt = left_val;
        end
      end
      OP_POP_FRONT:  val_nxt = right_val;
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

FILE: design/sorted_insert_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_insert_list_engine
// Bounded ordered list of signed values built from a row of shift cells.
// ----------------------------------------------------------------------------
// Use: each in_ beat carries an operation (push front, sorted insert, pop
// front, clear all) and a value. Each beat yields one out_ beat with a
// status, the head value and valid flag, and the entry count afterwards.
// Result: the result beat is registered and valid in the cycle after the in_ beat.
// Throughput: one beat per cycle unless a result waits on out_ready. Every
// cell compares and shifts in the same cycle; the insert search flag
// ripples through the row of CAPACITY cells, which sets the clock period.
// Stall: while a result waits on out_ready, in_ready stays low; it goes
// high in the cycle that result is taken, so a new beat enters then.
// Full list: pushes and inserts are rejected with status full.
// Empty list: pops return status pop on empty; head_value reads zero.
// Reset: clears the entry count and the result valid flag; slot contents
// are not cleared and are never shown above the count.
// ----------------------------------------------------------------------------
module sorted_insert_list_engine
  import sile_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic signed [ValueW-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [ValueW-1:0]    out_head_value,
  output logic                        out_head_valid,
  output logic [CountOutW-1:0]        out_entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [1:0]               status_r;
  logic [1:0]               status_nxt;
  logic                     out_valid_r;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     reject;
  sile_cmd_t                cmd;
  logic signed [ValueW-1:0] val [CAPACITY];
  logic                     pass [CAPACITY+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CapCount);
  assign empty    = (count_r == '0);

  always_comb begin
    reject     = 1'b0;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    case (in_operation) inside
      OP_PUSH_FRONT, OP_SORTED_INS: begin
        if (full) begin
          reject     = 1'b1;
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          reject     = 1'b1;
          status_nxt = ST_POP_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: count_nxt = '0;
    endcase
  end

  assign cmd.en    = accept && !reject;
  assign cmd.op    = in_operation;
  assign cmd.value = in_value;
  assign pass[0]   = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_v;
    logic signed [ValueW-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = in_value;
    end else begin : g_mid
      assign left_v = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = val[i];
    end else begin : g_body
      assign right_v = val[i+1];
    end

    sile_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (CW'(i) < count_r),
      .left_val  (left_v),
      .right_val (right_v),
      .pass_in   (pass[i]),
      .pass_out  (pass[i+1]),
      .val       (val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_head_valid  = !empty;
  assign out_head_value  = empty ? '0 : val[0];
  assign out_entry_count = CountOutW'(count_r);

endmodule

FILE: design/sile_checker.sv
// ----------------------------------------------------------------------------
// sile_checker
// Port-level checks of the sorted insert list engine, bound to the top.
// ----------------------------------------------------------------------------
module sile_checker
  import sile_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_operation,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_status,
  input logic                     out_head_valid,
  input logic [CountOutW-1:0]     out_entry_count
);

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_CLEAR_ALL) |=>
      (out_valid && out_status == ST_DONE && !out_head_valid &&
       out_entry_count == '0))
    else $error("clear did not leave an empty list");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |-> (out_entry_count == '0))
    else $error("empty head with nonzero count");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_POP_EMPTY) |-> !out_head_valid)
    else $error("pop on empty reported a head");

  a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_head_valid && out_entry_count == CountOutW'(CAPACITY)))
    else $error("full rejection without a full list");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_entry_count)))
    else $error("result beat changed while stalled");

endmodule

bind sorted_insert_list_engine sile_checker #(
  .CAPACITY (CAPACITY)
) u_sile_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_head_valid  (out_head_valid),
  .out_entry_count (out_entry_count)
);

FILE: tb/sorted_insert_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_list_engine_tb
// Self-checking bench for the sorted insert list engine.
// ----------------------------------------------------------------------------
// Beats go in through in_ and every result beat is matched against a list
// predictor kept in the bench. Directed corner tests (empty list, ordering
// with extreme and equal values, full list) are followed by random
// fill/drain rounds and mixed rounds, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_insert_list_engine_tb;
  import sile_pkg::*;

  localparam int CAP = 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] head_value;
    logic                     head_valid;
    logic [CountOutW-1:0]     entry_count;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_operation;
  logic signed [ValueW-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic signed [ValueW-1:0] out_head_value;
  logic                     out_head_valid;
  logic [CountOutW-1:0]     out_entry_count;

  logic signed [ValueW-1:0] list_vals [CAP];
  int                       list_len;
  list_result_t             result_q [$];
  int                       err_count;
  int                       idle_cycles = 0;
  bit                       src_quiet;
  bit                       snk_quiet;

  sorted_insert_list_engine #(
    .CAPACITY(CAP)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_head_value (out_head_value),
    .out_head_valid (out_head_valid),
    .out_entry_count(out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                 input logic signed [ValueW-1:0] val);
    list_result_t r;
    int pos;
    r.status = ST_DONE;
    case (op) inside
      OP_PUSH_FRONT, OP_SORTED_INS: begin
        if (list_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          if (op == OP_SORTED_INS) begin
            while (pos < list_len && list_vals[pos] < val) pos++;
          end
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_POP_FRONT: begin
        if (list_len == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          for (int i = 0; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.head_value  = (list_len > 0) ? list_vals[0] : '0;
    r.head_valid  = (list_len > 0);
    r.entry_count = CountOutW'(list_len);
    return r;
  endfunction

  function automatic int draw_gap(input bit quiet);
    int g;
    g = 0;
    if (!quiet && $urandom_range(0, 2) == 0) g = $urandom_range(0, 18);
    return g;
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 8) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2: if (list_len > 0) v = list_vals[$urandom_range(0, list_len - 1)];
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_op(input int unsigned wp, input int unsigned wi,
                                         input int unsigned wo, input int unsigned wc);
    int unsigned r;
    r = $urandom_range(0, wp + wi + wo + wc - 1);
    if (r < wp) return OP_PUSH_FRONT;
    if (r < wp + wi) return OP_SORTED_INS;
    if (r < wp + wi + wo) return OP_POP_FRONT;
    return OP_CLEAR_ALL;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [ValueW-1:0] val);
    int gap;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_value     = val;
    do @(posedge clk); while (!in_ready);
    result_q.push_back(apply_list_op(op, val));
    @(negedge clk);
  endtask

  task automatic run_ops(input int n, input int unsigned wp, input int unsigned wi,
                         input int unsigned wo, input int unsigned wc);
    repeat (n) send_beat(pick_op(wp, wi, wo, wc), pick_value());
  endtask

  task automatic shuffle_idling();
    src_quiet = ($urandom_range(0, 3) == 0);
    snk_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic test_empty_list();
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_CLEAR_ALL, $urandom);
  endtask

  task automatic test_ordering();
    send_beat(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_beat(OP_SORTED_INS, 32'h8000_0000);
    send_beat(OP_SORTED_INS, 32'h8000_0000);
    send_beat(OP_SORTED_INS, 32'h0000_0000);
    send_beat(OP_PUSH_FRONT, 32'h5555_5555);
    send_beat(OP_SORTED_INS, 32'hAAAA_AAAA);
  endtask

  task automatic test_full_list();
    while (list_len < CAP) send_beat(OP_SORTED_INS, pick_value());
    send_beat(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_beat(OP_SORTED_INS, 32'h8000_0000);
    send_beat(OP_POP_FRONT, $urandom);
    send_beat(OP_PUSH_FRONT, 32'h8000_0000);
    send_beat(OP_CLEAR_ALL, $urandom);
  endtask

  task automatic test_fill_drain();
    repeat (22) begin
      shuffle_idling();
      run_ops(24, 3, 6, 2, 0);
      run_ops(20, 1, 2, 8, 0);
      if ($urandom_range(0, 2) == 0) run_ops(1, 0, 0, 0, 1);
    end
  endtask

  task automatic test_mixed();
    repeat (7) begin
      shuffle_idling();
      run_ops(40, 4, 4, 4, 1);
    end
  endtask

  task automatic check_field(input string name, input logic [ValueW-1:0] exp_v,
                             input logic [ValueW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat expected none actual status %0d", $time,
                 out_status);
        err_count++;
      end else begin
        e = result_q.pop_front();
        check_field("status", 32'(e.status), 32'(out_status));
        check_field("head_value", e.head_value, out_head_value);
        check_field("head_valid", 32'(e.head_valid), 32'(out_head_valid));
        check_field("entry_count", 32'(e.entry_count), 32'(out_entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap(snk_quiet);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_PUSH_FRONT;
    in_value     = '0;
    list_len     = 0;
    err_count    = 0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_list();
    test_ordering();
    test_full_list();
    test_fill_drain();
    test_mixed();

    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sile_pkg.sv
design/sile_cell.sv
design/sorted_insert_list_engine.sv
design/sile_checker.sv
tb/sorted_insert_list_engine_tb.sv
